FILE: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, constants and control/status bundles for the LRU page
// replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // Field widths
    localparam int PAGE_W     = 16;
    localparam int TOTAL_W    = 24;
    localparam int SLOT_OUT_W = 3;
    localparam int FIU_W      = 4;

    // Stream data widths (packed fields, padded to whole bytes)
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAMES_IN_USE = 1'b0;   // word index, paddr[2]
    localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted reference, restart the scan
        logic scan_en;   // walk the frame table
        logic commit;    // apply the update and load the result register
    } lrupr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done; // last active frame is in the compare stage
        logic out_free;  // result register can take a new result
    } lrupr_sts_t;

endpackage

FILE: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement over a small frame set, with hit
// and fault totals and a frame count register.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake                    Payload
//  s_axis    in    s_axis_tvalid/tready         tdata: page; tlast: last_in_sequence
//  m_axis    out   m_axis_tvalid/tready         tdata: result fields; tlast: sequence_done
//  apb       in    psel/penable/pwrite/pready   frames_in_use at byte address 0
//
//  A reference is accepted, then the pages of the active frames are read, one
//  per cycle, through the single read port of the frame store and compared in
//  a compare stage behind the read, then the update is applied.
//  Reset clears all frames and totals at once; no clearing pass is needed.
//  A finished result waits in the output register while the next reference
//  is accepted; the update of the following one waits until it is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // reference stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lrupr_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [15:0] page
    input  logic                                 s_axis_tlast,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] is_fault, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted page,
    // [44:21] hit_total, [68:45] fault_total, [71:69] zero
    output logic [lrupr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    lrupr_pkg::lrupr_cmd_t cmd;
    lrupr_pkg::lrupr_sts_t sts;

    logic [lrupr_pkg::FIU_W-1:0] fiu_reg;

    // Register write
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg <= lrupr_pkg::FIU_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == lrupr_pkg::REG_FRAMES_IN_USE)) begin
            fiu_reg <= pwdata[lrupr_pkg::FIU_W-1:0];
        end
    end

    // Register read
    always_comb begin
        if (paddr[2] == lrupr_pkg::REG_FRAMES_IN_USE) begin
            prdata = {{(lrupr_pkg::APB_DATA_W - lrupr_pkg::FIU_W){1'b0}}, fiu_reg};
        end else begin
            prdata = '0;
        end
    end

    lrupr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lrupr_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .frames_in_use (fiu_reg),
        .in_page       (s_axis_tdata[lrupr_pkg::PAGE_W-1:0]),
        .in_last       (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer for one page reference: accept, scan the frames, commit.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  lrupr_pkg::lrupr_sts_t sts,
    output lrupr_pkg::lrupr_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && s_axis_tvalid;
    assign cmd.scan_en   = (state_reg == ST_SCAN);
    assign cmd.commit    = (state_reg == ST_UPDATE) && sts.out_free;

    // Checks
    a_commit_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $past(state_reg) == ST_SCAN || $past(state_reg) == ST_UPDATE)
        else $error("commit without a completed scan");

    a_load_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_SCAN)
        else $error("accepted reference did not start a scan");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_en || cmd.commit) |-> !s_axis_tready)
        else $error("input ready while a reference is in progress");

endmodule

FILE: rtl/lrupr_dp.sv
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame table, recency ranks, scan registers, totals and result register.
// ----------------------------------------------------------------------------
module lrupr_dp #(
    parameter int FRAMES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lrupr_pkg::lrupr_cmd_t                cmd,
    output lrupr_pkg::lrupr_sts_t                sts,
    input  logic [lrupr_pkg::FIU_W-1:0]          frames_in_use,
    input  logic [lrupr_pkg::PAGE_W-1:0]         in_page,
    input  logic                                 in_last,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lrupr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int PW     = lrupr_pkg::PAGE_W;
    localparam int TW     = lrupr_pkg::TOTAL_W;

    // Active frame count, clamped to 1..FRAMES
    logic [CNT_W-1:0] n_act;
    always_comb begin
        if (frames_in_use == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(frames_in_use) > FRAMES) begin
            n_act = CNT_W'(FRAMES);
        end else begin
            n_act = CNT_W'(frames_in_use);
        end
    end

    // Captured reference
    logic [PW-1:0] page_reg;
    logic          last_reg;

    // Scan pipeline: read stage then compare stage
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              cmp_vld_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic [PW-1:0]     rdata_reg;
    logic              rd_en;

    // Scan results
    logic              hit_found_reg, empty_found_reg, old_found_reg;
    logic [SLOT_W-1:0] hit_slot_reg, empty_slot_reg, old_slot_reg;
    logic [SLOT_W-1:0] old_rank_reg;
    logic [PW-1:0]     old_page_reg;

    // Update decision
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_evict;
    logic [31:0]       slot_wide;

    // Frame state
    logic [PW-1:0]     page_mem [FRAMES];
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0] rank_reg  [FRAMES];
    logic [SLOT_W-1:0] rank_next [FRAMES];
    logic [TW-1:0]     hits_reg, hits_next, faults_reg, faults_next;

    // Result register
    logic                            out_vld_reg;
    logic                            out_fault_reg, out_ev_vld_reg, out_last_reg;
    logic [lrupr_pkg::SLOT_OUT_W-1:0] out_slot_reg;
    logic [PW-1:0]                   out_ev_page_reg;
    logic [TW-1:0]                   out_hits_reg, out_faults_reg;

    assign rd_en = cmd.scan_en && (rd_idx_reg != n_act);

    assign sts.scan_done = (rd_idx_reg == n_act) && cmp_vld_reg;
    assign sts.out_free  = !out_vld_reg || m_axis_tready;

    // Capture the reference
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg <= in_page;
            last_reg <= in_last;
        end
    end

    // Frame page store: one write on commit, one registered read per scan step
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            page_mem[upd_slot] <= page_reg;
        end
        if (rd_en) begin
            rdata_reg <= page_mem[rd_idx_reg[SLOT_W-1:0]];
        end
    end

    // Read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= rd_en;
            if (cmd.load) begin
                rd_idx_reg <= '0;
            end else if (rd_en) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) cmp_idx_reg <= rd_idx_reg[SLOT_W-1:0];
    end

    // Compare stage: first hit, first empty frame, oldest frame
    logic              cmp_valid;
    logic [SLOT_W-1:0] cmp_rank;
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_rank  = rank_reg[cmp_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
        end else if (cmd.load) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            old_found_reg   <= 1'b0;
        end else if (cmp_vld_reg) begin
            if (!hit_found_reg && cmp_valid && (rdata_reg == page_reg)) begin
                hit_found_reg <= 1'b1;
            end
            if (!empty_found_reg && !cmp_valid) begin
                empty_found_reg <= 1'b1;
            end
            old_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_vld_reg) begin
            if (!hit_found_reg && cmp_valid && (rdata_reg == page_reg)) begin
                hit_slot_reg <= cmp_idx_reg;
            end
            if (!empty_found_reg && !cmp_valid) begin
                empty_slot_reg <= cmp_idx_reg;
            end
            // strict compare keeps the lowest frame on a tie
            if (!old_found_reg || (cmp_rank > old_rank_reg)) begin
                old_rank_reg <= cmp_rank;
                old_slot_reg <= cmp_idx_reg;
                old_page_reg <= rdata_reg;
            end
        end
    end

    // Update decision
    always_comb begin
        if (hit_found_reg) begin
            upd_slot = hit_slot_reg;
        end else if (empty_found_reg) begin
            upd_slot = empty_slot_reg;
        end else begin
            upd_slot = old_slot_reg;
        end
        upd_evict = !hit_found_reg && !empty_found_reg;
        slot_wide = 32'(upd_slot);
    end

    // Recency update: chosen frame becomes rank 0, younger valid frames age
    always_comb begin
        for (int g = 0; g < FRAMES; g++) begin
            if (SLOT_W'(g) == upd_slot) begin
                rank_next[g]  = '0;
                valid_next[g] = 1'b1;
            end else begin
                valid_next[g] = valid_reg[g];
                if (valid_reg[g] && (!valid_reg[upd_slot] ||
                                     (rank_reg[g] < rank_reg[upd_slot]))) begin
                    rank_next[g] = rank_reg[g] + SLOT_W'(1);
                end else begin
                    rank_next[g] = rank_reg[g];
                end
            end
        end
    end

    // Saturating totals
    always_comb begin
        hits_next   = hits_reg;
        faults_next = faults_reg;
        if (hit_found_reg) begin
            if (hits_reg != '1) hits_next = hits_reg + TW'(1);
        end else begin
            if (faults_reg != '1) faults_next = faults_reg + TW'(1);
        end
    end

    // Frame state and totals; end of sequence clears them after the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            faults_reg <= '0;
            for (int g = 0; g < FRAMES; g++) rank_reg[g] <= '0;
        end else if (cmd.commit) begin
            if (last_reg) begin
                valid_reg  <= '0;
                hits_reg   <= '0;
                faults_reg <= '0;
                for (int g = 0; g < FRAMES; g++) rank_reg[g] <= '0;
            end else begin
                valid_reg  <= valid_next;
                hits_reg   <= hits_next;
                faults_reg <= faults_next;
                for (int g = 0; g < FRAMES; g++) rank_reg[g] <= rank_next[g];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_fault_reg   <= !hit_found_reg;
            out_slot_reg    <= slot_wide[lrupr_pkg::SLOT_OUT_W-1:0];
            out_ev_vld_reg  <= upd_evict;
            out_ev_page_reg <= upd_evict ? old_page_reg : '0;
            out_hits_reg    <= hits_next;
            out_faults_reg  <= faults_next;
            out_last_reg    <= last_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_faults_reg, out_hits_reg, out_ev_page_reg,
                            out_ev_vld_reg, out_slot_reg, out_fault_reg};

    // Checks
    a_commit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result overwritten before transfer");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !out_fault_reg) |-> !out_ev_vld_reg)
        else $error("hit reported an eviction");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && last_reg) |=> (valid_reg == '0) && (hits_reg == '0)
                                     && (faults_reg == '0))
        else $error("end of sequence did not clear the frames");

endmodule

FILE: dv/lru_page_replacement_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Drives page references into the LRU page replacement block and checks every
// result transfer against an in-bench LRU predictor of the frame set: hit or
// fault, slot, eviction, running totals and the end-of-sequence echo.
// Directed cases cover cold fill, eviction order, out-of-range frame counts
// and frame count changes mid-sequence. Random reference strings over small
// working sets follow, with idle gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;

    localparam int TB_FRAMES = 8;

    // Result transfer as seen on {m_axis_tlast, m_axis_tdata}
    typedef struct packed {
        logic                          sequence_done;
        logic [2:0]                    pad;
        logic [lrupr_pkg::TOTAL_W-1:0] fault_total;
        logic [lrupr_pkg::TOTAL_W-1:0] hit_total;
        logic [lrupr_pkg::PAGE_W-1:0]  ev_page;
        logic                          evicted_valid;
        logic [2:0]                    frame_slot;
        logic                          is_fault;
    } ref_outcome_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [lrupr_pkg::S_TDATA_W-1:0]  s_axis_tdata;   // [15:0] page
    logic                             s_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // [0] is_fault, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted page,
    // [44:21] hit_total, [68:45] fault_total, [71:69] zero
    logic [lrupr_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [lrupr_pkg::APB_ADDR_W-1:0] paddr;
    logic [lrupr_pkg::APB_DATA_W-1:0] pwdata;
    logic [lrupr_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    // Predictor state: resident pages, valid marks, ages, totals, frame count
    logic [lrupr_pkg::PAGE_W-1:0]  res_page  [TB_FRAMES];
    bit                            res_valid [TB_FRAMES];
    int                            res_age   [TB_FRAMES];
    logic [lrupr_pkg::TOTAL_W-1:0] hits_pred;
    logic [lrupr_pkg::TOTAL_W-1:0] faults_pred;
    logic [lrupr_pkg::FIU_W-1:0]   frames_cfg;

    ref_outcome_t outcome_queue[$];

    bit tx_idle_en;
    bit rx_idle_en;
    int hold_len;
    int errors;
    int refs_sent;
    int results_checked;
    int hits_seen;
    int faults_seen;
    int evictions_seen;
    int seq_ends_seen;
    int cfg_writes;

    lru_page_replacement #(
        .FRAMES(TB_FRAMES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_frames();
        int f;
        for (f = 0; f < TB_FRAMES; f++) begin
            res_valid[f] = 1'b0;
            res_age[f]   = 0;
        end
        hits_pred   = '0;
        faults_pred = '0;
    endfunction

    // Look up one reference, update the frame set and return the outcome
    function automatic ref_outcome_t predict_reference(logic [lrupr_pkg::PAGE_W-1:0] page,
                                                       logic is_last);
        ref_outcome_t r;
        int  n;
        int  f;
        int  slot;
        int  oldest;
        int  prev_age;
        bit  hit;
        bit  free_found;

        r          = '0;
        hit        = 1'b0;
        free_found = 1'b0;
        slot       = 0;
        n = (frames_cfg == 0) ? 1 :
            (frames_cfg > TB_FRAMES) ? TB_FRAMES : int'(frames_cfg);

        // lowest active frame holding the page
        for (f = 0; f < n; f++) begin
            if (!hit && res_valid[f] && res_page[f] == page) begin
                hit  = 1'b1;
                slot = f;
            end
        end

        if (hit) begin
            if (hits_pred != '1) hits_pred++;
        end else begin
            if (faults_pred != '1) faults_pred++;
            for (f = 0; f < n; f++) begin
                if (!free_found && !res_valid[f]) begin
                    free_found = 1'b1;
                    slot       = f;
                end
            end
            // no empty frame: evict the oldest, lowest index on a tie
            if (!free_found) begin
                oldest = res_age[0];
                slot   = 0;
                for (f = 1; f < n; f++) begin
                    if (res_age[f] > oldest) begin
                        oldest = res_age[f];
                        slot   = f;
                    end
                end
                r.evicted_valid = 1'b1;
                r.ev_page       = res_page[slot];
            end
            res_page[slot] = page;
        end

        // make the slot most recent, aging every younger valid frame
        prev_age = res_valid[slot] ? res_age[slot] : TB_FRAMES;
        for (f = 0; f < TB_FRAMES; f++) begin
            if (f != slot && res_valid[f] && res_age[f] < prev_age) res_age[f]++;
        end
        res_age[slot]   = 0;
        res_valid[slot] = 1'b1;

        r.is_fault      = !hit;
        r.frame_slot    = 3'(slot);
        r.hit_total     = hits_pred;
        r.fault_total   = faults_pred;
        r.sequence_done = is_last;

        if (is_last) clear_frames();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(string name, logic [31:0] want,
                                          logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_outcome(ref_outcome_t got);
        ref_outcome_t want;
        if (outcome_queue.size() == 0) begin
            $error("result transfer with nothing expected: 0x%0h", got);
            errors++;
            return;
        end
        want = outcome_queue.pop_front();
        compare_field("is_fault",      32'(want.is_fault),      32'(got.is_fault));
        compare_field("frame_slot",    32'(want.frame_slot),    32'(got.frame_slot));
        compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
        compare_field("ev_page",       32'(want.ev_page),       32'(got.ev_page));
        compare_field("hit_total",     32'(want.hit_total),     32'(got.hit_total));
        compare_field("fault_total",   32'(want.fault_total),   32'(got.fault_total));
        compare_field("sequence_done", 32'(want.sequence_done), 32'(got.sequence_done));
        compare_field("tdata_pad",     32'(want.pad),           32'(got.pad));
        results_checked++;
        if (got.is_fault) faults_seen++; else hits_seen++;
        if (got.evicted_valid) evictions_seen++;
        if (got.sequence_done) seq_ends_seen++;
    endfunction

    // Result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                check_outcome(ref_outcome_t'({m_axis_tlast, m_axis_tdata}));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side ready: random stalls, or a long hold-off when requested
    initial begin
        int stall;
        int burst;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else begin
                stall = pick_gap(rx_idle_en);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(posedge aclk);
        end
    end

    // One reference transfer; the outcome is predicted at acceptance
    task automatic send_reference(input logic [lrupr_pkg::PAGE_W-1:0] page,
                                  input logic is_last);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tlast  <= is_last;
        do @(posedge aclk); while (!s_axis_tready);
        outcome_queue.push_back(predict_reference(page, is_last));
        refs_sent++;
    endtask

    // Stop offering and wait for every expected result, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outcome_queue.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Register access: setup cycle, access cycle until pready, then idle with psel low
    task automatic apb_access(input bit is_write,
                              input logic [lrupr_pkg::APB_DATA_W-1:0] wdata,
                              output logic [lrupr_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Change the frame count while idle and read it back
    task automatic set_frames(input logic [lrupr_pkg::FIU_W-1:0] count);
        logic [lrupr_pkg::APB_DATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, lrupr_pkg::APB_DATA_W'(count), rd);
        frames_cfg = count;
        cfg_writes++;
        apb_access(1'b0, '0, rd);
        compare_field("frames_in_use readback", lrupr_pkg::APB_DATA_W'(count), rd);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset frame count of eight: fill, hit, LRU evictions, sequence restart
    task automatic test_cold_fill();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);   // hit
        send_reference(16'h5555, 1'b0);
        send_reference(16'hAAAA, 1'b0);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'hFF00, 1'b0);
        send_reference(16'h0F0F, 1'b0);
        send_reference(16'hF0F0, 1'b0);   // last empty frame
        send_reference(16'h1234, 1'b0);   // evicts the oldest
        send_reference(16'h0000, 1'b0);   // hit
        send_reference(16'hFFFF, 1'b1);   // fault, end of sequence
        send_reference(16'hFFFF, 1'b0);   // cleared set: fault again in slot 0
    endtask

    // Frame count of zero acts as one; above eight acts as eight
    task automatic test_frame_limits();
        set_frames(4'd0);
        send_reference(16'h0003, 1'b0);
        send_reference(16'h0004, 1'b0);   // evicts the only frame
        send_reference(16'h0004, 1'b1);   // hit
        set_frames(4'd15);
    endtask

    // Shrink and regrow the active set in the middle of a sequence
    task automatic test_frame_resize();
        int i;
        for (i = 0; i < 5; i++) send_reference(16'h00A0 + 16'(i), 1'b0);
        set_frames(4'd2);
        send_reference(16'h00A3, 1'b0);   // resident above the active set: miss
        send_reference(16'h00A4, 1'b0);
        set_frames(4'd9);
        send_reference(16'h00A2, 1'b0);   // frame reactivated: hit
        send_reference(16'h00A4, 1'b0);   // duplicate page, lowest frame wins
        send_reference(16'h00A0, 1'b1);
    endtask

    // Hold the result side off while references keep coming
    task automatic test_output_backpressure();
        int i;
        drain_results();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_len   = 300;
        for (i = 0; i < 30; i++) send_reference(16'h0C00 + 16'(i % 10), i == 29);
    endtask

    // Random reference strings over small working sets, frame count changes
    task automatic test_random_sequences(input int n_refs);
        logic [lrupr_pkg::FIU_W-1:0]  extremes [4] = '{4'd1, 4'd8, 4'd0, 4'd15};
        logic [lrupr_pkg::PAGE_W-1:0] base;
        logic [lrupr_pkg::PAGE_W-1:0] page;
        int sent;
        int cfg_idx;
        int seq_len;
        int split_at;
        int span;
        int i;
        int r;
        sent    = 0;
        cfg_idx = 0;
        while (sent < n_refs) begin
            if (cfg_idx < 4) begin
                set_frames(extremes[cfg_idx]);
                cfg_idx++;
            end else if ($urandom_range(0, 2) == 0) begin
                set_frames(lrupr_pkg::FIU_W'($urandom_range(0, 15)));
            end
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            seq_len = (r < 10) ? $urandom_range(1, 4) :
                      (r < 80) ? $urandom_range(5, 40) : $urandom_range(41, 120);
            if (seq_len > n_refs - sent) seq_len = n_refs - sent;
            split_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, seq_len) : 0;
            base = lrupr_pkg::PAGE_W'($urandom);
            span = $urandom_range(1, 12);
            for (i = 0; i < seq_len; i++) begin
                if (i == split_at && i != 0)
                    set_frames(lrupr_pkg::FIU_W'($urandom_range(0, 15)));
                // mostly the working set, some stray pages
                if ($urandom_range(0, 9) == 0) page = lrupr_pkg::PAGE_W'($urandom);
                else page = base + lrupr_pkg::PAGE_W'($urandom_range(0, span - 1));
                send_reference(page, i == seq_len - 1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        hold_len      = 0;
        errors        = 0;
        clear_frames();
        frames_cfg    = lrupr_pkg::FIU_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_cold_fill();
        test_frame_limits();
        test_frame_resize();
        test_output_backpressure();
        test_random_sequences(720);

        drain_results();
        repeat (30) @(posedge aclk);

        $display("Sent %0d references over %0d frame count writes; %0d results checked",
                 refs_sent, cfg_writes, results_checked);
        $display("Seen %0d hits, %0d faults, %0d evictions, %0d sequence ends",
                 hits_seen, faults_seen, evictions_seen, seq_ends_seen);
        if (errors == 0 && outcome_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
